@@ src/gop_pkg.sv @@
// Package for the gated outer-product accumulator: word types, operation codes,
// sum geometry and the upper-triangle slot table. No dependencies.
package gop_pkg;

   localparam int TERMS            = 6;
   localparam int PAIRS            = 21;
   localparam int AMP_BITS         = 16;
   localparam int SUM_BITS         = 64;
   localparam int INDEX_BITS       = 3;
   localparam int SLOT_BITS        = 5;
   localparam int DETECTORS_DEF    = 2;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   typedef logic [SLOT_BITS-1:0] slot_type;

   // first slot of each upper-triangle row
   localparam slot_type ROW_BASE [TERMS] = '{5'd0, 5'd6, 5'd11, 5'd15, 5'd18, 5'd20};

   typedef struct packed {
      logic                  operation;
      logic                  detector;
      logic                  common_present;
      logic [AMP_BITS-1:0]   common_amp;
      logic [AMP_BITS-1:0]   tower_one;
      logic [AMP_BITS-1:0]   tower_two;
      logic [AMP_BITS-1:0]   tower_three;
      logic [AMP_BITS-1:0]   tower_four;
      logic [INDEX_BITS-1:0] read_row;
      logic [INDEX_BITS-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [SUM_BITS-1:0] sum_value;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic add;
      logic det;
   } lane_ctrl_type;

   typedef struct packed {
      logic     fire;
      logic     accepted;
      logic     read_hit;
      slot_type slot;
   } merge_ctrl_type;

endpackage

@@ src/gated_outer_product_accumulator.sv @@
// Gated outer-product accumulator, top level: qualification, 21 product lanes, merge.
// Accepted request words pass the stage-one and merge registers; one word per cycle
// while not stalled. Each lane is a registered multiply then one saturating add.
// Sums update in the cycle the word leaves the product stage, so reads see prior events.
// Synchronous reset clears all sums and empties the pipeline.
// Depends on gop_pkg, gop_lane, gop_merge.
module gated_outer_product_accumulator
   import gop_pkg::*;
#(
   parameter int DETECTORS   = DETECTORS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int WIDE_BITS = SAMPLE_BITS + AMP_BITS;

   logic                          advance;
   logic                          accept;
   logic                          fire;
   logic [AMP_BITS-1:0]           amp [TERMS-1];
   logic signed [SAMPLE_BITS-1:0] terms [TERMS];
   logic [WIDE_BITS-1:0]          wide [TERMS-1];
   logic                          qualified;
   logic [INDEX_BITS-1:0]         lo_index;
   logic [INDEX_BITS-1:0]         hi_index;
   logic                          index_ok;
   slot_type                      slot;
   logic                          det_ok;
   logic [SUM_BITS-1:0]           lane_values [PAIRS];
   lane_ctrl_type                 lane_ctrl;
   merge_ctrl_type                merge_ctrl;

   logic     s1_valid_ff;
   logic     s1_valid_in;
   logic     s1_op_ff;
   logic     s1_det_ff;
   logic     s1_qual_ff;
   logic     s1_index_ok_ff;
   slot_type s1_slot_ff;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign fire      = s1_valid_ff && advance;

   assign amp[0] = req_data.common_amp;
   assign amp[1] = req_data.tower_one;
   assign amp[2] = req_data.tower_two;
   assign amp[3] = req_data.tower_three;
   assign amp[4] = req_data.tower_four;

   always_comb begin
      for (int i = 0; i < TERMS - 1; i++) begin
         wide[i]  = {{SAMPLE_BITS{1'b0}}, amp[i]};
         terms[i] = wide[i][SAMPLE_BITS-1:0];
      end
      terms[TERMS-1] = SAMPLE_BITS'(1);
   end

   assign qualified = req_data.common_present && (terms[1] != '0) && (terms[2] != '0) &&
                      (terms[3] != '0) && (terms[4] != '0);

   always_comb begin
      if (req_data.read_row > req_data.read_col) begin
         lo_index = req_data.read_col;
         hi_index = req_data.read_row;
      end else begin
         lo_index = req_data.read_row;
         hi_index = req_data.read_col;
      end
      index_ok = (hi_index < INDEX_BITS'(TERMS));
      slot     = '0;
      if (index_ok) begin
         slot = ROW_BASE[lo_index] + SLOT_BITS'(hi_index - lo_index);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_data.operation;
         s1_det_ff      <= req_data.detector;
         s1_qual_ff     <= qualified;
         s1_index_ok_ff <= index_ok;
         s1_slot_ff     <= slot;
      end
   end

   assign det_ok = (int'(s1_det_ff) < DETECTORS);

   assign lane_ctrl.capture = accept;
   assign lane_ctrl.add     = fire && (s1_op_ff == OP_ACCUMULATE) && s1_qual_ff && det_ok;
   assign lane_ctrl.det     = s1_det_ff;

   for (genvar i = 0; i < TERMS; i++) begin : g_row
      for (genvar j = i; j < TERMS; j++) begin : g_col
         localparam int K = int'(ROW_BASE[i]) + j - i;
         gop_lane #(
            .DETECTORS  (DETECTORS),
            .SAMPLE_BITS(SAMPLE_BITS)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (lane_ctrl),
            .a         (terms[i]),
            .b         (terms[j]),
            .read_value(lane_values[K])
         );
      end
   end

   assign merge_ctrl.fire     = fire;
   assign merge_ctrl.accepted = (s1_op_ff == OP_ACCUMULATE) && s1_qual_ff && det_ok;
   assign merge_ctrl.read_hit = (s1_op_ff == OP_READ) && s1_index_ok_ff && det_ok;
   assign merge_ctrl.slot     = s1_slot_ff;

   gop_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (merge_ctrl),
      .lane_values(lane_values),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

@@ src/gop_lane.sv @@
// One product lane: registered multiply of two terms, then a saturating add
// into this slot's per-detector sum. Depends on gop_pkg.
module gop_lane
   import gop_pkg::*;
#(
   parameter int DETECTORS   = DETECTORS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctrl_type                 ctrl,
   input  logic signed [SAMPLE_BITS-1:0] a,
   input  logic signed [SAMPLE_BITS-1:0] b,
   output logic [SUM_BITS-1:0]           read_value
);

   localparam int PROD_BITS = 2 * SAMPLE_BITS;

   logic signed [PROD_BITS-1:0] product_ff;
   logic [SUM_BITS-1:0]         sum_ff [DETECTORS];
   logic [SUM_BITS-1:0]         term;
   logic [SUM_BITS-1:0]         raw_sum;
   logic [SUM_BITS-1:0]         sum_in;
   logic [DETECTORS-1:0]        sel;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         product_ff <= a * b;
      end
   end

   always_comb begin
      read_value = '0;
      for (int d = 0; d < DETECTORS; d++) begin
         sel[d] = (int'(ctrl.det) == d);
         if (sel[d]) begin
            read_value = sum_ff[d];
         end
      end
   end

   assign term    = {{(SUM_BITS-PROD_BITS){product_ff[PROD_BITS-1]}}, product_ff};
   assign raw_sum = read_value + term;

   always_comb begin
      sum_in = raw_sum;
      if (read_value[SUM_BITS-1] == term[SUM_BITS-1] &&
          raw_sum[SUM_BITS-1] != read_value[SUM_BITS-1]) begin
         sum_in = read_value[SUM_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
      end
   end

   for (genvar d = 0; d < DETECTORS; d++) begin : g_det
      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[d] <= '0;
         end else if (ctrl.add && sel[d]) begin
            sum_ff[d] <= sum_in;
         end
      end
   end

endmodule

@@ src/gop_merge.sv @@
// Merge stage: picks the requested lane sum for a read and holds the result
// word until the consumer takes it. Depends on gop_pkg.
module gop_merge
   import gop_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  merge_ctrl_type      ctrl,
   input  logic [SUM_BITS-1:0] lane_values [PAIRS],
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.accepted  = ctrl.accepted;
      rsp_data_in.sum_value = '0;
      if (ctrl.read_hit) begin
         rsp_data_in.sum_value = lane_values[ctrl.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/gated_outer_product_accumulator_tb.sv @@
`timescale 1ns / 100ps
// Testbench for gated_outer_product_accumulator: directed and random event and read words,
// checked against an in-bench model of the per-detector moment sums.
// Depends on gop_pkg and the accumulator top level.
module gated_outer_product_accumulator_tb;
   import gop_pkg::*;

   typedef enum int {
      MODE_STEADY,
      MODE_SENDER_GAPS,
      MODE_RECEIVER_STALLS,
      MODE_BOTH
   } idle_mode_type;

   localparam int RANDOM_WORDS = 500;
   localparam int PHASES       = 4;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type       pending_words[$];
   rsp_type       pending_results[$];
   logic          req_taken;
   idle_mode_type idle_mode;
   int            fail_count;

   // upper-triangle sums kept at [low index][high index]
   logic signed [SUM_BITS-1:0] moment_sums [DETECTORS_DEF][TERMS][TERMS];

   gated_outer_product_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("gated_outer_product_accumulator verification failed");
      $finish;
   end

   function automatic logic signed [SUM_BITS-1:0] saturating_add(
      input logic signed [SUM_BITS-1:0] acc,
      input logic signed [SUM_BITS-1:0] term
   );
      logic signed [SUM_BITS-1:0] total;
      total = acc + term;
      if (acc[SUM_BITS-1] == term[SUM_BITS-1] && total[SUM_BITS-1] != acc[SUM_BITS-1]) begin
         if (acc[SUM_BITS-1])
            return {1'b1, {(SUM_BITS-1){1'b0}}};
         return {1'b0, {(SUM_BITS-1){1'b1}}};
      end
      return total;
   endfunction

   task automatic accumulate_or_read(input req_type w, output rsp_type r);
      logic signed [SUM_BITS-1:0] v [TERMS];
      int lo;
      int hi;
      r = '0;
      if (w.operation == OP_READ) begin
         if (w.read_row < TERMS && w.read_col < TERMS) begin
            lo = (w.read_row < w.read_col) ? w.read_row : w.read_col;
            hi = (w.read_row < w.read_col) ? w.read_col : w.read_row;
            r.sum_value = moment_sums[w.detector][lo][hi];
         end
      end else begin
         v[0] = {{(SUM_BITS-AMP_BITS){w.common_amp[AMP_BITS-1]}}, w.common_amp};
         v[1] = {{(SUM_BITS-AMP_BITS){w.tower_one[AMP_BITS-1]}}, w.tower_one};
         v[2] = {{(SUM_BITS-AMP_BITS){w.tower_two[AMP_BITS-1]}}, w.tower_two};
         v[3] = {{(SUM_BITS-AMP_BITS){w.tower_three[AMP_BITS-1]}}, w.tower_three};
         v[4] = {{(SUM_BITS-AMP_BITS){w.tower_four[AMP_BITS-1]}}, w.tower_four};
         v[5] = 1;
         if (w.common_present && v[1] != 0 && v[2] != 0 && v[3] != 0 && v[4] != 0) begin
            for (int i = 0; i < TERMS; i++)
               for (int j = i; j < TERMS; j++)
                  moment_sums[w.detector][i][j] =
                     saturating_add(moment_sums[w.detector][i][j], v[i] * v[j]);
            r.accepted = 1'b1;
         end
      end
   endtask

   function automatic req_type make_event(input logic det, input logic present,
                                          input logic [AMP_BITS-1:0] c,
                                          input logic [AMP_BITS-1:0] t1,
                                          input logic [AMP_BITS-1:0] t2,
                                          input logic [AMP_BITS-1:0] t3,
                                          input logic [AMP_BITS-1:0] t4);
      req_type w;
      w = '0;
      w.operation      = OP_ACCUMULATE;
      w.detector       = det;
      w.common_present = present;
      w.common_amp     = c;
      w.tower_one      = t1;
      w.tower_two      = t2;
      w.tower_three    = t3;
      w.tower_four     = t4;
      w.read_row       = INDEX_BITS'($urandom);
      w.read_col       = INDEX_BITS'($urandom);
      return w;
   endfunction

   function automatic req_type make_read(input logic det, input int row, input int col);
      req_type w;
      w = req_type'({$urandom, $urandom, $urandom});
      w.operation = OP_READ;
      w.detector  = det;
      w.read_row  = INDEX_BITS'(row);
      w.read_col  = INDEX_BITS'(col);
      return w;
   endfunction

   function automatic logic [AMP_BITS-1:0] random_amp();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         default: return AMP_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [AMP_BITS-1:0] nonzero_amp();
      logic [AMP_BITS-1:0] a;
      a = random_amp();
      if (a == 0)
         a = 16'h0001;
      return a;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      roll;
      int      gap;
      roll = $urandom_range(99);
      if (roll < 65) begin
         w = make_event(1'($urandom_range(1)), 1'b1, random_amp(), nonzero_amp(),
                        nonzero_amp(), nonzero_amp(), nonzero_amp());
      end else if (roll < 75) begin
         w = make_event(1'($urandom_range(1)), 1'($urandom_range(1)), random_amp(),
                        nonzero_amp(), nonzero_amp(), nonzero_amp(), nonzero_amp());
         gap = $urandom_range(4);
         case (gap)
            0: w.tower_one   = '0;
            1: w.tower_two   = '0;
            2: w.tower_three = '0;
            3: w.tower_four  = '0;
            default: w.common_present = 1'b0;
         endcase
      end else begin
         w = make_read(1'($urandom_range(1)),
                       ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5),
                       ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5));
      end
      return w;
   endfunction

   function automatic logic sender_idles();
      case (idle_mode)
         MODE_SENDER_GAPS: return $urandom_range(99) < 58;
         MODE_BOTH:        return $urandom_range(99) < 10;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (idle_mode)
         MODE_RECEIVER_STALLS: return $urandom_range(99) < 58;
         MODE_BOTH:            return $urandom_range(99) < 10;
         default:              return 1'b0;
      endcase
   endfunction

   // driver: advance on the falling edge, hold the word while it is not taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_words.size() != 0 && !sender_idles()) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= receiver_stalls();
      end
   end

   // monitor: check the response word first, then predict the accepted request word
   always @(posedge clock) begin
      rsp_type got_word;
      rsp_type exp_word;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_word = rsp_data;
            if (pending_results.size() == 0) begin
               $error("unexpected response word: accepted %0b sum_value %0d",
                      got_word.accepted, $signed(got_word.sum_value));
               fail_count++;
            end else begin
               exp_word = pending_results.pop_front();
               if (got_word.accepted !== exp_word.accepted) begin
                  $error("accepted: expected %0b, actual %0b",
                         exp_word.accepted, got_word.accepted);
                  fail_count++;
               end
               if (got_word.sum_value !== exp_word.sum_value) begin
                  $error("sum_value: expected %0d, actual %0d",
                         $signed(exp_word.sum_value), $signed(got_word.sum_value));
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            accumulate_or_read(req_data, exp_word);
            pending_results.push_back(exp_word);
         end
      end
   end

   initial begin
      fail_count = 0;
      idle_mode  = MODE_STEADY;
      req_taken  = 1'b0;
      req_valid  = 1'b0;
      rsp_stall  = 1'b0;
      req_data   = '0;
      reset      = 1'b1;
      for (int d = 0; d < DETECTORS_DEF; d++)
         for (int i = 0; i < TERMS; i++)
            for (int j = 0; j < TERMS; j++)
               moment_sums[d][i][j] = '0;

      // sums are zero after reset
      pending_words.push_back(make_read(1'b0, 0, 0));
      pending_words.push_back(make_read(1'b1, 5, 5));
      // extreme amplitudes, both signs
      pending_words.push_back(make_event(1'b0, 1'b1, 16'h8000, 16'h7fff, 16'h8000,
                                         16'h0001, 16'hffff));
      pending_words.push_back(make_event(1'b1, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff,
                                         16'h7fff, 16'h7fff));
      pending_words.push_back(make_event(1'b1, 1'b1, 16'h8000, 16'h8000, 16'h8000,
                                         16'h8000, 16'h8000));
      // common channel absent
      pending_words.push_back(make_event(1'b0, 1'b0, 16'h1234, 16'h0005, 16'h0006,
                                         16'h0007, 16'h0008));
      // each tower at zero
      pending_words.push_back(make_event(1'b0, 1'b1, 16'h0100, 16'h0000, 16'h0002,
                                         16'h0003, 16'h0004));
      pending_words.push_back(make_event(1'b0, 1'b1, 16'h0100, 16'h0001, 16'h0000,
                                         16'h0003, 16'h0004));
      pending_words.push_back(make_event(1'b0, 1'b1, 16'h0100, 16'h0001, 16'h0002,
                                         16'h0000, 16'h0004));
      pending_words.push_back(make_event(1'b0, 1'b1, 16'h0100, 16'h0001, 16'h0002,
                                         16'h0003, 16'h0000));
      // common at zero still qualifies
      pending_words.push_back(make_event(1'b0, 1'b1, 16'h0000, 16'hfff0, 16'h0011,
                                         16'h0022, 16'hff00));
      // count, plain, mirrored and out-of-range reads
      pending_words.push_back(make_read(1'b0, 5, 5));
      pending_words.push_back(make_read(1'b0, 0, 1));
      pending_words.push_back(make_read(1'b0, 1, 0));
      pending_words.push_back(make_read(1'b0, 4, 2));
      pending_words.push_back(make_read(1'b0, 2, 4));
      pending_words.push_back(make_read(1'b1, 5, 0));
      pending_words.push_back(make_read(1'b1, 3, 3));
      pending_words.push_back(make_read(1'b1, 6, 0));
      pending_words.push_back(make_read(1'b0, 0, 7));
      pending_words.push_back(make_read(1'b1, 7, 7));
      pending_words.push_back(make_read(1'b1, 5, 5));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         while (pending_words.size() != 0 || req_valid)
            @(posedge clock);
         @(negedge clock);
         idle_mode = idle_mode_type'(p);
         for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
            pending_words.push_back(random_word());
      end

      while (pending_words.size() != 0 || req_valid)
         @(posedge clock);
      @(negedge clock);
      idle_mode = MODE_STEADY;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (pending_results.size() != 0) begin
         $error("%0d expected response words never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("gated_outer_product_accumulator verification clean");
      else
         $display("gated_outer_product_accumulator verification failed");
      $finish;
   end

endmodule
